// File: hdl/icmp_er_pkg.sv
`timescale 1ns / 1ps

package icmp_er_pkg;

   localparam int LANE_BITS   = 64;
   localparam int NUM_LANES   = 8;
   localparam int BEAT_BITS   = LANE_BITS * NUM_LANES;
   localparam int ENABLE_BITS = 64;
   localparam int COUNT_BITS  = 64;
   // nine 16-bit header words summed, checksum word left out
   localparam int SUM_BITS    = 20;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // byte offsets within the first beat
   localparam int MAC_DST_BYTE   = 0;
   localparam int MAC_SRC_BYTE   = 6;
   localparam int MAC_BYTES      = 6;
   localparam int IP_HDR_BYTE    = 14;
   localparam int TTL_BYTE       = 22;
   localparam int IP_CSUM_BYTE   = 24;
   localparam int IP_SRC_BYTE    = 26;
   localparam int IP_DST_BYTE    = 30;
   localparam int IP_ADDR_BYTES  = 4;
   localparam int ICMP_TYPE_BYTE = 34;
   localparam int ICMP_CODE_BYTE = 35;
   localparam int ICMP_CSUM_BYTE = 36;

   localparam logic [7:0]  ECHO_REQUEST_TYPE = 8'd8;
   localparam logic [7:0]  ECHO_REPLY_TYPE   = 8'd0;
   localparam logic [7:0]  ECHO_CODE         = 8'd0;
   localparam logic [7:0]  REPLY_TTL         = 8'd128;
   localparam logic [15:0] ICMP_TYPE_PATCH   = 16'h0800;

   typedef struct packed {
      logic [BEAT_BITS-1:0]   beat;
      logic [ENABLE_BITS-1:0] enables;
      logic                   last;
      logic                   forwarded;
      logic                   rewrite;
      logic [SUM_BITS-1:0]    ip_sum;
      logic [COUNT_BITS-1:0]  count;
   } entry_type;

   typedef struct packed {
      logic                  inspecting;
      logic [COUNT_BITS-1:0] count;
   } front_status_type;

   function automatic logic [7:0] get_byte(input logic [BEAT_BITS-1:0] beat,
                                           input int unsigned idx);
      return beat[8*idx +: 8];
   endfunction

   // big-endian 16-bit word starting at byte idx
   function automatic logic [15:0] get_word(input logic [BEAT_BITS-1:0] beat,
                                            input int unsigned idx);
      return {beat[8*idx +: 8], beat[8*(idx+1) +: 8]};
   endfunction

endpackage

// File: hdl/icmp_echo_responder_core.sv
// ICMP echo responder. Every beat pushed in yields one result beat, in order. The first beat of
// a packet carrying an echo request (type 8, code 0) comes out as an echo reply: MAC and IP
// addresses swapped, TTL 128, IPv4 header checksum recomputed, type 0 and the ICMP checksum
// patched by 0x0800 with end-around carry; later beats of that packet pass unchanged.
// Beats of any other packet come out with forwarded low and lanes and enables zero.
// packet_count is the number of end_of_packet beats accepted before this beat.
// Throughput is one beat per clock when neither full nor a withheld pop stalls the flow; a beat passes
// through the classify queue and then the rewrite output register to the result side. The queue
// between classify and rewrite holds QUEUE_DEPTH beats, so full and pop stall independently.
`timescale 1ns / 1ps

module icmp_echo_responder_core #(
   parameter int QUEUE_DEPTH = icmp_er_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [63:0] req_lane0_bits,
   input  logic [63:0] req_lane1_bits,
   input  logic [63:0] req_lane2_bits,
   input  logic [63:0] req_lane3_bits,
   input  logic [63:0] req_lane4_bits,
   input  logic [63:0] req_lane5_bits,
   input  logic [63:0] req_lane6_bits,
   input  logic [63:0] req_lane7_bits,
   input  logic [63:0] req_byte_enables,
   input  logic        req_end_of_packet,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_out_lane0,
   output logic [63:0] rsp_out_lane1,
   output logic [63:0] rsp_out_lane2,
   output logic [63:0] rsp_out_lane3,
   output logic [63:0] rsp_out_lane4,
   output logic [63:0] rsp_out_lane5,
   output logic [63:0] rsp_out_lane6,
   output logic [63:0] rsp_out_lane7,
   output logic [63:0] rsp_out_enables,
   output logic        rsp_out_last,
   output logic        rsp_forwarded,
   output logic [63:0] rsp_packet_count
);
   import icmp_er_pkg::*;

   logic [BEAT_BITS-1:0] in_beat;
   logic [BEAT_BITS-1:0] out_beat;
   logic                 q_push, q_full, q_pop, q_empty;
   entry_type            q_push_entry, q_pop_entry;
   front_status_type     front_status;
   logic                 out_valid;

   assign in_beat = {req_lane7_bits, req_lane6_bits, req_lane5_bits, req_lane4_bits,
                     req_lane3_bits, req_lane2_bits, req_lane1_bits, req_lane0_bits};

   icmp_er_front u_front (
      .clock       (clock),
      .reset       (reset),
      .beat_valid  (push),
      .beat        (in_beat),
      .enables     (req_byte_enables),
      .last        (req_end_of_packet),
      .queue_full  (q_full),
      .queue_push  (q_push),
      .queue_entry (q_push_entry),
      .status      (front_status)
   );

   icmp_er_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry),
      .empty      (q_empty)
   );

   icmp_er_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_entry   (q_pop_entry),
      .queue_empty   (q_empty),
      .queue_pop     (q_pop),
      .out_valid     (out_valid),
      .out_pop       (pop),
      .out_beat      (out_beat),
      .out_enables   (rsp_out_enables),
      .out_last      (rsp_out_last),
      .out_forwarded (rsp_forwarded),
      .out_count     (rsp_packet_count)
   );

   assign full  = q_full;
   assign empty = !out_valid;

   assign rsp_out_lane0 = out_beat[0*LANE_BITS +: LANE_BITS];
   assign rsp_out_lane1 = out_beat[1*LANE_BITS +: LANE_BITS];
   assign rsp_out_lane2 = out_beat[2*LANE_BITS +: LANE_BITS];
   assign rsp_out_lane3 = out_beat[3*LANE_BITS +: LANE_BITS];
   assign rsp_out_lane4 = out_beat[4*LANE_BITS +: LANE_BITS];
   assign rsp_out_lane5 = out_beat[5*LANE_BITS +: LANE_BITS];
   assign rsp_out_lane6 = out_beat[6*LANE_BITS +: LANE_BITS];
   assign rsp_out_lane7 = out_beat[7*LANE_BITS +: LANE_BITS];

`ifndef SYNTHESIS
   // last beat always puts the front back to header inspection
   a_eop_rearms: assert property (@(posedge clock) disable iff (reset)
      (push && !full && req_end_of_packet) |=> front_status.inspecting)
      else $error("phase not back to inspect after last beat");

   a_eop_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !full && req_end_of_packet) |=>
      (front_status.count == $past(front_status.count) + COUNT_BITS'(1)))
      else $error("packet count did not advance on last beat");

   a_drop_zeroed: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_forwarded) |->
      (rsp_out_enables == '0 && rsp_out_lane0 == '0 && rsp_out_lane4 == '0))
      else $error("dropped beat carries data");

   a_queue_no_overrun: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");
`endif

endmodule

// File: hdl/icmp_er_front.sv
`timescale 1ns / 1ps

module icmp_er_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          beat_valid,
   input  logic [icmp_er_pkg::BEAT_BITS-1:0]   beat,
   input  logic [icmp_er_pkg::ENABLE_BITS-1:0] enables,
   input  logic                          last,
   input  logic                          queue_full,
   output logic                          queue_push,
   output icmp_er_pkg::entry_type        queue_entry,
   output icmp_er_pkg::front_status_type status
);
   import icmp_er_pkg::*;

   typedef enum logic [1:0] {
      PH_INSPECT,
      PH_FORWARD,
      PH_DROP
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  accept;
   logic                  is_request;
   logic                  forward;
   logic                  rewrite;
   logic [SUM_BITS-1:0]   ip_sum;

   assign accept     = beat_valid && !queue_full;
   assign queue_push = accept;

   assign is_request = (get_byte(beat, ICMP_TYPE_BYTE) == ECHO_REQUEST_TYPE) &&
                       (get_byte(beat, ICMP_CODE_BYTE) == ECHO_CODE);

   // address swaps leave the sum unchanged; TTL word already carries the new TTL
   assign ip_sum = SUM_BITS'(get_word(beat, IP_HDR_BYTE))
                 + SUM_BITS'(get_word(beat, IP_HDR_BYTE + 2))
                 + SUM_BITS'(get_word(beat, IP_HDR_BYTE + 4))
                 + SUM_BITS'(get_word(beat, IP_HDR_BYTE + 6))
                 + SUM_BITS'({REPLY_TTL, get_byte(beat, TTL_BYTE + 1)})
                 + SUM_BITS'(get_word(beat, IP_SRC_BYTE))
                 + SUM_BITS'(get_word(beat, IP_SRC_BYTE + 2))
                 + SUM_BITS'(get_word(beat, IP_DST_BYTE))
                 + SUM_BITS'(get_word(beat, IP_DST_BYTE + 2));

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      forward  = 1'b0;
      rewrite  = 1'b0;
      case (phase_ff)
         PH_INSPECT: begin
            forward  = is_request;
            rewrite  = is_request;
            phase_in = is_request ? PH_FORWARD : PH_DROP;
         end
         PH_FORWARD: begin
            forward = 1'b1;
         end
         default: begin
            forward = 1'b0;
         end
      endcase
      if (last) begin
         phase_in = PH_INSPECT;
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_INSPECT;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      queue_entry.beat      = beat;
      queue_entry.enables   = enables;
      queue_entry.last      = last;
      queue_entry.forwarded = forward;
      queue_entry.rewrite   = rewrite;
      queue_entry.ip_sum    = ip_sum;
      queue_entry.count     = count_ff;
   end

   assign status.inspecting = (phase_ff == PH_INSPECT);
   assign status.count      = count_ff;

endmodule

// File: hdl/icmp_er_queue.sv
`timescale 1ns / 1ps

module icmp_er_queue #(
   parameter int DEPTH = icmp_er_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  icmp_er_pkg::entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output icmp_er_pkg::entry_type pop_entry,
   output logic                   empty
);
   import icmp_er_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   entry_type           slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full    = (fill_ff == FULL_CNT);
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign pop_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hdl/icmp_er_back.sv
`timescale 1ns / 1ps

module icmp_er_back (
   input  logic                                clock,
   input  logic                                reset,
   input  icmp_er_pkg::entry_type              queue_entry,
   input  logic                                queue_empty,
   output logic                                queue_pop,
   output logic                                out_valid,
   input  logic                                out_pop,
   output logic [icmp_er_pkg::BEAT_BITS-1:0]   out_beat,
   output logic [icmp_er_pkg::ENABLE_BITS-1:0] out_enables,
   output logic                                out_last,
   output logic                                out_forwarded,
   output logic [icmp_er_pkg::COUNT_BITS-1:0]  out_count
);
   import icmp_er_pkg::*;

   logic                   valid_ff, valid_in;
   logic [BEAT_BITS-1:0]   beat_ff, beat_in;
   logic [ENABLE_BITS-1:0] enables_ff, enables_in;
   logic                   last_ff;
   logic                   forwarded_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic                   load;
   logic [16:0]            ip_fold;
   logic [15:0]            ip_csum;
   logic [16:0]            icmp_sum;
   logic [15:0]            icmp_csum;

   // output register refills whenever it is empty or being drained
   assign load      = !queue_empty && (!valid_ff || out_pop);
   assign queue_pop = load;

   // two end-around folds cover any nine-word sum
   assign ip_fold   = {1'b0, queue_entry.ip_sum[15:0]} + 17'(queue_entry.ip_sum[SUM_BITS-1:16]);
   assign ip_csum   = ~(ip_fold[15:0] + 16'(ip_fold[16]));
   assign icmp_sum  = {1'b0, get_word(queue_entry.beat, ICMP_CSUM_BYTE)} + {1'b0, ICMP_TYPE_PATCH};
   assign icmp_csum = icmp_sum[15:0] + 16'(icmp_sum[16]);

   always_comb begin
      beat_in    = queue_entry.beat;
      enables_in = queue_entry.enables;
      if (queue_entry.rewrite) begin
         for (int k = 0; k < MAC_BYTES; k++) begin
            beat_in[8*(MAC_DST_BYTE+k) +: 8] = get_byte(queue_entry.beat, MAC_SRC_BYTE + k);
            beat_in[8*(MAC_SRC_BYTE+k) +: 8] = get_byte(queue_entry.beat, MAC_DST_BYTE + k);
         end
         for (int k = 0; k < IP_ADDR_BYTES; k++) begin
            beat_in[8*(IP_SRC_BYTE+k) +: 8] = get_byte(queue_entry.beat, IP_DST_BYTE + k);
            beat_in[8*(IP_DST_BYTE+k) +: 8] = get_byte(queue_entry.beat, IP_SRC_BYTE + k);
         end
         beat_in[8*TTL_BYTE +: 8]           = REPLY_TTL;
         beat_in[8*IP_CSUM_BYTE +: 8]       = ip_csum[15:8];
         beat_in[8*(IP_CSUM_BYTE+1) +: 8]   = ip_csum[7:0];
         beat_in[8*ICMP_TYPE_BYTE +: 8]     = ECHO_REPLY_TYPE;
         beat_in[8*ICMP_CSUM_BYTE +: 8]     = icmp_csum[15:8];
         beat_in[8*(ICMP_CSUM_BYTE+1) +: 8] = icmp_csum[7:0];
      end
      if (!queue_entry.forwarded) begin
         beat_in    = '0;
         enables_in = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff      <= beat_in;
         enables_ff   <= enables_in;
         last_ff      <= queue_entry.last;
         forwarded_ff <= queue_entry.forwarded;
         count_ff     <= queue_entry.count;
      end
   end

   assign out_valid     = valid_ff;
   assign out_beat      = beat_ff;
   assign out_enables   = enables_ff;
   assign out_last      = last_ff;
   assign out_forwarded = forwarded_ff;
   assign out_count     = count_ff;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import icmp_er_pkg::*;

   typedef enum logic [1:0] {
      PH_INSPECT = 2'd0,
      PH_FORWARD = 2'd1,
      PH_DROP    = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BEAT_BITS-1:0]   data;
      logic [ENABLE_BITS-1:0] en;
      logic                   eop;
   } beat_type;

   typedef struct packed {
      logic [BEAT_BITS-1:0]   data;
      logic [ENABLE_BITS-1:0] en;
      logic                   last;
      logic                   fwd;
      logic [COUNT_BITS-1:0]  count;
   } reply_type;

   localparam int GAP_MAX       = 10;
   localparam int IDLE_LIMIT    = 1000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_BEATS  = 2000;
   localparam int REPORT_LIMIT  = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push  = 1'b0;
   logic pop   = 1'b0;
   logic full;
   logic empty;
   beat_type req_beat = '0;

   logic [63:0] rsp_out_lane0, rsp_out_lane1, rsp_out_lane2, rsp_out_lane3;
   logic [63:0] rsp_out_lane4, rsp_out_lane5, rsp_out_lane6, rsp_out_lane7;
   logic [63:0] rsp_out_enables;
   logic        rsp_out_last;
   logic        rsp_forwarded;
   logic [63:0] rsp_packet_count;

   beat_type  beats_pending[$];
   reply_type replies_due[$];

   // predictor state
   phase_type             phase = PH_INSPECT;
   logic [COUNT_BITS-1:0] pkts_seen = '0;

   int  errors = 0;
   int  idle_cycles = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  req_calm = 0;
   int  rsp_calm = 0;
   bit  push_fired = 1'b0;
   bit  pop_fired = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   icmp_echo_responder_core u_top (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_lane0_bits    (req_beat.data[0*64 +: 64]),
      .req_lane1_bits    (req_beat.data[1*64 +: 64]),
      .req_lane2_bits    (req_beat.data[2*64 +: 64]),
      .req_lane3_bits    (req_beat.data[3*64 +: 64]),
      .req_lane4_bits    (req_beat.data[4*64 +: 64]),
      .req_lane5_bits    (req_beat.data[5*64 +: 64]),
      .req_lane6_bits    (req_beat.data[6*64 +: 64]),
      .req_lane7_bits    (req_beat.data[7*64 +: 64]),
      .req_byte_enables  (req_beat.en),
      .req_end_of_packet (req_beat.eop),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_lane0     (rsp_out_lane0),
      .rsp_out_lane1     (rsp_out_lane1),
      .rsp_out_lane2     (rsp_out_lane2),
      .rsp_out_lane3     (rsp_out_lane3),
      .rsp_out_lane4     (rsp_out_lane4),
      .rsp_out_lane5     (rsp_out_lane5),
      .rsp_out_lane6     (rsp_out_lane6),
      .rsp_out_lane7     (rsp_out_lane7),
      .rsp_out_enables   (rsp_out_enables),
      .rsp_out_last      (rsp_out_last),
      .rsp_forwarded     (rsp_forwarded),
      .rsp_packet_count  (rsp_packet_count)
   );

   // Echo request -> reply rewrite plus forward/drop tracking per packet.
   function automatic reply_type echo_predict(input beat_type b);
      reply_type             r;
      logic [BEAT_BITS-1:0]  d;
      logic [7:0]            tmp;
      logic [31:0]           sum;
      logic [16:0]           ck;
      logic [15:0]           ck_fold;
      int                    k;
      d = b.data;
      r.count = pkts_seen;
      if (phase == PH_INSPECT) begin
         if (d[8*ICMP_TYPE_BYTE +: 8] == ECHO_REQUEST_TYPE &&
             d[8*ICMP_CODE_BYTE +: 8] == ECHO_CODE) begin
            for (k = 0; k < MAC_BYTES; k++) begin
               tmp = d[8*(MAC_DST_BYTE+k) +: 8];
               d[8*(MAC_DST_BYTE+k) +: 8] = d[8*(MAC_SRC_BYTE+k) +: 8];
               d[8*(MAC_SRC_BYTE+k) +: 8] = tmp;
            end
            d[8*TTL_BYTE +: 8] = REPLY_TTL;
            for (k = 0; k < IP_ADDR_BYTES; k++) begin
               tmp = d[8*(IP_SRC_BYTE+k) +: 8];
               d[8*(IP_SRC_BYTE+k) +: 8] = d[8*(IP_DST_BYTE+k) +: 8];
               d[8*(IP_DST_BYTE+k) +: 8] = tmp;
            end
            sum = '0;
            for (k = IP_HDR_BYTE; k < ICMP_TYPE_BYTE; k += 2)
               if (k != IP_CSUM_BYTE)
                  sum += {d[8*k +: 8], d[8*(k+1) +: 8]};
            while (sum > 32'h0000_FFFF)
               sum = {16'h0, sum[15:0]} + (sum >> 16);
            d[8*IP_CSUM_BYTE +: 8]     = ~sum[15:8];
            d[8*(IP_CSUM_BYTE+1) +: 8] = ~sum[7:0];
            ck = {1'b0, d[8*ICMP_CSUM_BYTE +: 8], d[8*(ICMP_CSUM_BYTE+1) +: 8]}
                 + {1'b0, ICMP_TYPE_PATCH};
            // single end-around carry, 0xFFFF kept as is
            ck_fold = ck[15:0] + {15'h0, ck[16]};
            d[8*ICMP_TYPE_BYTE +: 8]     = ECHO_REPLY_TYPE;
            d[8*ICMP_CSUM_BYTE +: 8]     = ck_fold[15:8];
            d[8*(ICMP_CSUM_BYTE+1) +: 8] = ck_fold[7:0];
            phase = PH_FORWARD;
         end else begin
            phase = PH_DROP;
         end
      end
      if (phase == PH_FORWARD) begin
         r.data = d;
         r.en   = b.en;
         r.fwd  = 1'b1;
      end else begin
         r.data = '0;
         r.en   = '0;
         r.fwd  = 1'b0;
      end
      r.last = b.eop;
      if (b.eop) begin
         phase = PH_INSPECT;
         pkts_seen++;
      end
      return r;
   endfunction

   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 50);
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   function automatic logic [BEAT_BITS-1:0] rand_data();
      logic [BEAT_BITS-1:0] d;
      for (int k = 0; k < BEAT_BITS / 32; k++)
         d[32*k +: 32] = $urandom;
      return d;
   endfunction

   function automatic logic [ENABLE_BITS-1:0] rand_enables();
      if ($urandom_range(0, 3) == 0)
         return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] rand_icmp_csum();
      case ($urandom_range(0, 11))
         0: return 16'hFFFF;
         1: return 16'hF7FF;
         2: return 16'hF800;
         3: return 16'h0000;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   function automatic logic [BEAT_BITS-1:0] with_icmp(input logic [BEAT_BITS-1:0] d,
                                                      input logic [7:0] ty,
                                                      input logic [7:0] code,
                                                      input logic [15:0] csum);
      d[8*ICMP_TYPE_BYTE +: 8]     = ty;
      d[8*ICMP_CODE_BYTE +: 8]     = code;
      d[8*ICMP_CSUM_BYTE +: 8]     = csum[15:8];
      d[8*(ICMP_CSUM_BYTE+1) +: 8] = csum[7:0];
      return d;
   endfunction

   task automatic add_beat(input logic [BEAT_BITS-1:0] d, input logic [ENABLE_BITS-1:0] en,
                           input logic eop);
      beat_type b;
      b.data = d;
      b.en   = en;
      b.eop  = eop;
      beats_pending.push_back(b);
   endtask

   // first beat, then random body beats, end_of_packet on the final one
   task automatic add_packet(input logic [BEAT_BITS-1:0] head, input int n_beats);
      for (int k = 0; k < n_beats; k++)
         add_beat(k == 0 ? head : rand_data(), rand_enables(), k == n_beats - 1);
   endtask

   task automatic check_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
      end
   endtask

   // driver
   always @(posedge clock) begin
      push_fired = !reset && push && !full;
      if (push_fired)
         replies_due.push_back(echo_predict(req_beat));
   end

   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push_fired) begin
            void'(beats_pending.pop_front());
            req_gap = draw_gap(req_calm);
         end
         if (push && !push_fired) begin
            // beat still waiting on full, hold it
         end else if (req_gap > 0) begin
            push <= 1'b0;
            req_gap--;
         end else if (beats_pending.size() != 0) begin
            push     <= 1'b1;
            req_beat <= beats_pending[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      pop_fired = !reset && pop && !empty;
      if (pop_fired) begin
         got.data  = {rsp_out_lane7, rsp_out_lane6, rsp_out_lane5, rsp_out_lane4,
                      rsp_out_lane3, rsp_out_lane2, rsp_out_lane1, rsp_out_lane0};
         got.en    = rsp_out_enables;
         got.last  = rsp_out_last;
         got.fwd   = rsp_forwarded;
         got.count = rsp_packet_count;
         if (replies_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: result beat with nothing expected: expected none, actual %h",
                        $time, got);
         end else begin
            want = replies_due.pop_front();
            for (int k = 0; k < NUM_LANES; k++)
               check_field($sformatf("out_lane%0d", k), want.data[64*k +: 64],
                           got.data[64*k +: 64]);
            check_field("out_enables", want.en, got.en);
            check_field("out_last", 64'(want.last), 64'(got.last));
            check_field("forwarded", 64'(want.fwd), 64'(got.fwd));
            check_field("packet_count", want.count, got.count);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop_fired)
            rsp_gap = draw_gap(rsp_calm);
         if (pop && !pop_fired) begin
            // keep pop up until a beat is taken
         end else if (rsp_gap > 0) begin
            pop <= 1'b0;
            rsp_gap--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any beat moving
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [BEAT_BITS-1:0] d;
      int                   kind;

      // directed
      add_beat('0, '0, 1'b1);
      add_beat('1, '1, 1'b1);
      add_beat(with_icmp('0, ECHO_REQUEST_TYPE, ECHO_CODE, 16'h0000), '1, 1'b1);
      add_beat(with_icmp('1, ECHO_REQUEST_TYPE, ECHO_CODE, 16'hFFFF), '1, 1'b1);
      add_beat(with_icmp(rand_data(), ECHO_REQUEST_TYPE, ECHO_CODE, 16'hF7FF), '1, 1'b1);
      add_beat(with_icmp(rand_data(), ECHO_REQUEST_TYPE, ECHO_CODE, 16'hF800), '0, 1'b1);
      // multi-beat request; body beat that itself looks like a request
      add_beat(with_icmp(rand_data(), ECHO_REQUEST_TYPE, ECHO_CODE, 16'h1234), '1, 1'b0);
      add_beat(with_icmp('1, ECHO_REQUEST_TYPE, ECHO_CODE, 16'hFFFF), '1, 1'b0);
      add_beat(rand_data(), 64'h0000_0000_FFFF_FFFF, 1'b1);
      // wrong code, wrong type, reply type
      add_beat(with_icmp(rand_data(), ECHO_REQUEST_TYPE, 8'd1, 16'h0), '1, 1'b0);
      add_beat(rand_data(), '1, 1'b1);
      add_beat(with_icmp(rand_data(), 8'd9, ECHO_CODE, 16'h0), '1, 1'b1);
      add_beat(with_icmp(rand_data(), ECHO_REPLY_TYPE, ECHO_CODE, 16'h0), '1, 1'b1);
      // dropped packet whose later beat looks like a request
      add_beat(with_icmp('0, 8'hFF, 8'hFF, 16'h0), '1, 1'b0);
      add_beat(with_icmp('1, ECHO_REQUEST_TYPE, ECHO_CODE, 16'h0), '1, 1'b1);
      add_beat(with_icmp('1, ECHO_REQUEST_TYPE, ECHO_CODE, 16'h0), '0, 1'b1);

      // random: mostly well-formed requests, then non-requests, noise and near misses
      while (beats_pending.size() < RANDOM_BEATS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            d = with_icmp(rand_data(), ECHO_REQUEST_TYPE, ECHO_CODE, rand_icmp_csum());
            add_packet(d, $urandom_range(0, 7) == 0 ? $urandom_range(5, 8)
                                                    : $urandom_range(1, 4));
         end else if (kind == 6) begin
            add_packet(rand_data(), $urandom_range(1, 4));
         end else if (kind == 7) begin
            add_beat(rand_data(), rand_enables(), 1'($urandom_range(0, 1)));
         end else if (kind == 8) begin
            d = with_icmp(rand_data(), ECHO_REQUEST_TYPE, 8'($urandom_range(1, 255)),
                          rand_icmp_csum());
            add_packet(d, $urandom_range(1, 3));
         end else begin
            d = rand_data();
            d[8*ICMP_CODE_BYTE +: 8] = ECHO_CODE;
            if (d[8*ICMP_TYPE_BYTE +: 8] == ECHO_REQUEST_TYPE)
               d[8*ICMP_TYPE_BYTE +: 8] = ECHO_REPLY_TYPE;
            add_packet(d, $urandom_range(1, 3));
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (beats_pending.size() != 0 || replies_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
